### src/axis_vector_rotator_defines.svh
// Assertion macros for the axis_vector_rotator checker.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef AXIS_VECTOR_ROTATOR_DEFINES_SVH
`define AXIS_VECTOR_ROTATOR_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define AVR_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("axis_vector_rotator: same-cycle check failed");

// Next-cycle implication, quiet while reset is asserted.
`define AVR_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("axis_vector_rotator: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define AVR_ASSERT_RESET(label, pre, post) \
    label: assert property (@(posedge aclk) (pre) |=> (post)) \
        else $error("axis_vector_rotator: reset check failed");

`endif

### src/avr_pkg.sv
// Shared types, widths and constants of the vector rotator.
// Elaboration-time helpers build the arctangent terms and the CORDIC gain.
package avr_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int DATA_WIDTH   = 32;
    localparam int GUARD        = 24;

    localparam int VEC_W = 32;
    localparam int ANG_W = 26;
    localparam int ACC_W = 64;
    localparam int RED_W = 25;              // angle reduced into [0, 360)
    localparam int ROT_W = 24;              // angle folded into [-90, 90]
    localparam int QW    = ACC_W - GUARD;   // component width after rescale
    localparam int OUT_W = (DATA_WIDTH < VEC_W) ? DATA_WIDTH : VEC_W;

    // Degree constants in Q16.16
    localparam int FULL_TURN    = 23592960;
    localparam int HALF_TURN    = 11796480;
    localparam int QUARTER_TURN = 5898240;

    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [38:0] DEG_TO_RAD = 39'((PI_Q60 >> 16) / 64'd180);

    // Saturation limits of an output component
    localparam logic signed [QW-1:0] CLIP_HI = QW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] CLIP_LO = -CLIP_HI - QW'(1);

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z,
        AXIS_BAD
    } axis_t;

    // Word fields carried alongside the rotation datapath
    typedef struct packed {
        axis_t                   mode;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } side_t;

    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] u;
        logic signed [ACC_W-1:0] v;
        logic signed [ACC_W-1:0] z;
        side_t                   side;
    } rot_bus_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] out_x;
        logic signed [VEC_W-1:0] out_y;
        logic signed [VEC_W-1:0] out_z;
        logic                    saturated;
        logic                    bad_axis;
    } out_t;

    // Unsigned quotient by shift and subtract, for the constant tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          j;
        rem = '0;
        quo = '0;
        for (j = 63; j >= 0; j--) begin
            rem = {rem[63:0], num[j]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[j] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-idx) in Q60, series terms truncated
    function automatic logic [63:0] atan_q60(input int unsigned idx);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] k;
        logic [63:0] t;
        int          j;
        sum = '0;
        k   = '0;
        if (idx == 0) return PI_Q60 >> 2;
        if (idx >= 60) return '0;
        p = 64'd1 << (60 - idx);
        for (j = 0; j < 64; j++) begin
            if (p != 64'd0) begin
                t = udiv64(p, 64'd2 * k + 64'd1);
                if (k[0]) begin
                    sum = sum - t;
                end else begin
                    sum = sum + t;
                end
                p = (2 * idx < 64) ? (p >> (2 * idx)) : 64'd0;
                k = k + 64'd1;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        int          j;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (j = 0; j < 32; j++) begin
            if (b > n) b = b >> 2;
        end
        for (j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 1/K in Q32 for exactly CORDIC_STEPS micro-rotations
    function automatic logic [63:0] inv_gain_q32();
        logic [63:0] p;
        int          i;
        p = 64'h8000_0000_0000_0000;
        for (i = 0; i < CORDIC_STEPS; i++) begin
            if (2 * i <= 62) p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
        end
        return isqrt64(p << 1);
    endfunction

    localparam logic [31:0] INV_GAIN = 32'(inv_gain_q32());

endpackage

### src/axis_vector_rotator.sv
// Vector rotator top level: rotates a Q16.16 3D vector about the x, y or z axis
// by an angle in Q16.16 degrees, using a fully unrolled CORDIC pipeline.
// Throughput is one word per cycle while the output buffer has room; a word passes
// through 3 angle-preparation stages, 24 micro-rotation stages, 3 gain and
// saturation stages, and a 2-entry output buffer. The whole pipeline holds
// while the output buffer is full, so s_ready drops only when two results wait
// on m_ready; it does not depend on m_ready in the same cycle.
// Depends on avr_pkg, avr_angle_prep, avr_cordic and avr_gain_comp.
module axis_vector_rotator
    import avr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_mode,
    input  logic signed [ANG_W-1:0] s_angle_deg,
    input  logic signed [VEC_W-1:0] s_vec_x,
    input  logic signed [VEC_W-1:0] s_vec_y,
    input  logic signed [VEC_W-1:0] s_vec_z,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VEC_W-1:0] m_out_x,
    output logic signed [VEC_W-1:0] m_out_y,
    output logic signed [VEC_W-1:0] m_out_z,
    output logic                    m_saturated,
    output logic                    m_bad_axis
);

    localparam logic [1:0] SKID_DEPTH = 2'd2;

    logic     adv;
    rot_bus_t prep_bus;
    rot_bus_t rot_bus;
    logic     res_valid;
    out_t     res_data;

    out_t       buf_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    avr_angle_prep u_angle_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_valid),
        .in_mode  (s_mode),
        .in_angle (s_angle_deg),
        .in_x     (s_vec_x),
        .in_y     (s_vec_y),
        .in_z     (s_vec_z),
        .out_bus  (prep_bus)
    );

    avr_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_bus  (prep_bus),
        .out_bus (rot_bus)
    );

    avr_gain_comp u_gain_comp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_bus    (rot_bus),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Advance the pipeline while the output buffer has room
    assign adv     = (cnt_reg != SKID_DEPTH);
    assign s_ready = adv;
    assign push    = adv && res_valid;
    assign pop     = m_valid && m_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // Store finished words
    always_ff @(posedge aclk) begin
        if (push) buf_reg[wr_ptr_reg] <= res_data;
    end

    assign m_valid     = (cnt_reg != 2'd0);
    assign m_out_x     = buf_reg[rd_ptr_reg].out_x;
    assign m_out_y     = buf_reg[rd_ptr_reg].out_y;
    assign m_out_z     = buf_reg[rd_ptr_reg].out_z;
    assign m_saturated = buf_reg[rd_ptr_reg].saturated;
    assign m_bad_axis  = buf_reg[rd_ptr_reg].bad_axis;

endmodule

### src/avr_angle_prep.sv
// Front end of the rotator: angle reduction, quadrant fold and radian scaling.
// Depends on avr_pkg; feeds the CORDIC stages with a rot_bus_t word.
module avr_angle_prep
    import avr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [1:0]              in_mode,
    input  logic signed [ANG_W-1:0] in_angle,
    input  logic signed [VEC_W-1:0] in_x,
    input  logic signed [VEC_W-1:0] in_y,
    input  logic signed [VEC_W-1:0] in_z,
    output rot_bus_t                out_bus
);

    localparam int EXT_W = ANG_W + 2;
    localparam int CU_W  = VEC_W + 1;
    localparam logic signed [39:0] DEG_K_S = {1'b0, DEG_TO_RAD};

    // Stage 1: angle modulo one turn, pick the two rotated components
    logic                    vld1_reg;
    side_t                   side1_reg, side1_next;
    logic [RED_W-1:0]        red1_reg, red1_next;
    logic signed [VEC_W-1:0] cu1_reg, cu1_next;
    logic signed [VEC_W-1:0] cv1_reg, cv1_next;
    logic signed [EXT_W-1:0] ang_ext, red_sum;

    // Stage 2: fold into [-90, 90], negate the pair on a half-turn move
    logic                    vld2_reg;
    side_t                   side2_reg;
    logic signed [ROT_W-1:0] rot2_reg, rot2_next;
    logic signed [CU_W-1:0]  cu2_reg, cu2_next;
    logic signed [CU_W-1:0]  cv2_reg, cv2_next;
    logic signed [RED_W:0]   diff_half, diff_full;
    logic                    flip;

    // Stage 3: degrees to Q60 radians, components to guard scale
    logic                    vld3_reg;
    side_t                   side3_reg;
    logic signed [ACC_W-1:0] z3_reg, z3_next;
    logic signed [ACC_W-1:0] u3_reg, u3_next;
    logic signed [ACC_W-1:0] v3_reg, v3_next;

    always_comb begin
        side1_next.mode = axis_t'(in_mode);
        side1_next.x    = in_x;
        side1_next.y    = in_y;
        side1_next.z    = in_z;

        ang_ext = EXT_W'(in_angle);
        if (ang_ext < -FULL_TURN) begin
            red_sum = ang_ext + EXT_W'(2 * FULL_TURN);
        end else if (ang_ext < 0) begin
            red_sum = ang_ext + EXT_W'(FULL_TURN);
        end else if (ang_ext >= FULL_TURN) begin
            red_sum = ang_ext - EXT_W'(FULL_TURN);
        end else begin
            red_sum = ang_ext;
        end
        red1_next = RED_W'(red_sum);

        unique case (axis_t'(in_mode))
            AXIS_X: begin
                cu1_next = in_y;
                cv1_next = in_z;
            end
            AXIS_Y: begin
                cu1_next = in_z;
                cv1_next = in_x;
            end
            AXIS_Z: begin
                cu1_next = in_x;
                cv1_next = in_y;
            end
            AXIS_BAD: begin
                cu1_next = in_x;
                cv1_next = in_y;
            end
        endcase
    end

    always_comb begin
        diff_half = $signed({1'b0, red1_reg}) - (RED_W + 1)'(HALF_TURN);
        diff_full = $signed({1'b0, red1_reg}) - (RED_W + 1)'(FULL_TURN);
        if (red1_reg <= RED_W'(QUARTER_TURN)) begin
            rot2_next = ROT_W'(red1_reg);
            flip      = 1'b0;
        end else if (red1_reg < RED_W'(3 * QUARTER_TURN)) begin
            rot2_next = ROT_W'(diff_half);
            flip      = 1'b1;
        end else begin
            rot2_next = ROT_W'(diff_full);
            flip      = 1'b0;
        end
        cu2_next = flip ? -CU_W'(cu1_reg) : CU_W'(cu1_reg);
        cv2_next = flip ? -CU_W'(cv1_reg) : CU_W'(cv1_reg);
    end

    always_comb begin
        z3_next = rot2_reg * DEG_K_S;
        u3_next = ACC_W'(cu2_reg) <<< GUARD;
        v3_next = ACC_W'(cv2_reg) <<< GUARD;
    end

    // Advance valid bits with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // Advance payload; hold on stall
    always_ff @(posedge aclk) begin
        if (adv) begin
            side1_reg <= side1_next;
            red1_reg  <= red1_next;
            cu1_reg   <= cu1_next;
            cv1_reg   <= cv1_next;
            side2_reg <= side1_reg;
            rot2_reg  <= rot2_next;
            cu2_reg   <= cu2_next;
            cv2_reg   <= cv2_next;
            side3_reg <= side2_reg;
            z3_reg    <= z3_next;
            u3_reg    <= u3_next;
            v3_reg    <= v3_next;
        end
    end

    always_comb begin
        out_bus.valid = vld3_reg;
        out_bus.u     = u3_reg;
        out_bus.v     = v3_reg;
        out_bus.z     = z3_reg;
        out_bus.side  = side3_reg;
    end

endmodule

### src/avr_cordic.sv
// Unrolled CORDIC rotation: one registered micro-rotation per stage.
// Depends on avr_pkg for the arctangent terms and the rot_bus_t word.
module avr_cordic
    import avr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     adv,
    input  rot_bus_t in_bus,
    output rot_bus_t out_bus
);

    rot_bus_t stage_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [ACC_W-1:0] ATAN_I = ACC_W'(atan_q60(i));

        rot_bus_t step_in;
        rot_bus_t step_next;

        if (i == 0) begin : g_first
            assign step_in = in_bus;
        end else begin : g_rest
            assign step_in = stage_reg[i - 1];
        end

        // Rotate toward zero residual angle
        always_comb begin
            step_next = step_in;
            if (!step_in.z[ACC_W-1]) begin
                step_next.u = step_in.u - (step_in.v >>> i);
                step_next.v = step_in.v + (step_in.u >>> i);
                step_next.z = step_in.z - ATAN_I;
            end else begin
                step_next.u = step_in.u + (step_in.v >>> i);
                step_next.v = step_in.v - (step_in.u >>> i);
                step_next.z = step_in.z + ATAN_I;
            end
        end

        // Advance stage; clear only the valid bit on reset
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stage_reg[i].valid <= 1'b0;
            end else if (adv) begin
                stage_reg[i] <= step_next;
            end
        end
    end

    assign out_bus = stage_reg[CORDIC_STEPS - 1];

endmodule

### src/avr_gain_comp.sv
// Back end: CORDIC gain removal, rounding, saturation and output assembly.
// Depends on avr_pkg; produces one out_t word per valid input word.
module avr_gain_comp
    import avr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     adv,
    input  rot_bus_t in_bus,
    output logic     res_valid,
    output out_t     res_data
);

    localparam logic signed [32:0]      INV_GAIN_S = {1'b0, INV_GAIN};
    localparam logic signed [ACC_W-1:0] RND        = ACC_W'(64'sd1 <<< (GUARD - 1));

    typedef struct packed {
        logic signed [VEC_W-1:0] val;
        logic                    sat;
    } clip_t;

    function automatic clip_t clip_q(input logic signed [QW-1:0] val);
        clip_t res;
        res.sat = 1'b1;
        if (val > CLIP_HI) begin
            res.val = VEC_W'(CLIP_HI);
        end else if (val < CLIP_LO) begin
            res.val = VEC_W'(CLIP_LO);
        end else begin
            res.val = VEC_W'(val);
            res.sat = 1'b0;
        end
        return res;
    endfunction

    // Stage 1: high and low partial products of u and v by 1/K
    logic                    vld1_reg;
    side_t                   side1_reg;
    logic signed [ACC_W-1:0] hu1_reg, hu1_next, hv1_reg, hv1_next;
    logic [ACC_W-1:0]        lu1_reg, lu1_next, lv1_reg, lv1_next;

    // Stage 2: combine partial products and add the rounding half
    logic                    vld2_reg;
    side_t                   side2_reg;
    logic signed [ACC_W-1:0] mu2_reg, mu2_next, mv2_reg, mv2_next;

    // Stage 3: rescale, clip and place components by axis
    logic                    vld3_reg;
    out_t                    res3_reg, res3_next;
    clip_t                   cu, cv, cax, cay, caz;

    always_comb begin
        hu1_next = $signed(in_bus.u[ACC_W-1:32]) * INV_GAIN_S;
        hv1_next = $signed(in_bus.v[ACC_W-1:32]) * INV_GAIN_S;
        lu1_next = in_bus.u[31:0] * INV_GAIN;
        lv1_next = in_bus.v[31:0] * INV_GAIN;
    end

    always_comb begin
        mu2_next = hu1_reg + $signed({32'd0, lu1_reg[ACC_W-1:32]}) + RND;
        mv2_next = hv1_reg + $signed({32'd0, lv1_reg[ACC_W-1:32]}) + RND;
    end

    always_comb begin
        cu  = clip_q(mu2_reg[ACC_W-1:GUARD]);
        cv  = clip_q(mv2_reg[ACC_W-1:GUARD]);
        cax = clip_q(QW'(side2_reg.x));
        cay = clip_q(QW'(side2_reg.y));
        caz = clip_q(QW'(side2_reg.z));
        res3_next.bad_axis = 1'b0;
        unique case (side2_reg.mode)
            AXIS_X: begin
                res3_next.out_x     = cax.val;
                res3_next.out_y     = cu.val;
                res3_next.out_z     = cv.val;
                res3_next.saturated = cax.sat | cu.sat | cv.sat;
            end
            AXIS_Y: begin
                res3_next.out_x     = cv.val;
                res3_next.out_y     = cay.val;
                res3_next.out_z     = cu.val;
                res3_next.saturated = cay.sat | cu.sat | cv.sat;
            end
            AXIS_Z: begin
                res3_next.out_x     = cu.val;
                res3_next.out_y     = cv.val;
                res3_next.out_z     = caz.val;
                res3_next.saturated = caz.sat | cu.sat | cv.sat;
            end
            AXIS_BAD: begin
                res3_next.out_x     = side2_reg.x;
                res3_next.out_y     = side2_reg.y;
                res3_next.out_z     = side2_reg.z;
                res3_next.saturated = 1'b0;
                res3_next.bad_axis  = 1'b1;
            end
        endcase
    end

    // Advance valid bits with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= in_bus.valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // Advance payload; hold on stall
    always_ff @(posedge aclk) begin
        if (adv) begin
            side1_reg <= in_bus.side;
            hu1_reg   <= hu1_next;
            hv1_reg   <= hv1_next;
            lu1_reg   <= lu1_next;
            lv1_reg   <= lv1_next;
            side2_reg <= side1_reg;
            mu2_reg   <= mu2_next;
            mv2_reg   <= mv2_next;
            res3_reg  <= res3_next;
        end
    end

    assign res_valid = vld3_reg;
    assign res_data  = res3_reg;

endmodule

### src/avr_checker.sv
// Port-level checks of the vector rotator, bound to the top level.
// Depends on avr_pkg and the assertion macros of axis_vector_rotator_defines.svh.
`include "axis_vector_rotator_defines.svh"

module avr_checker
    import avr_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [VEC_W-1:0] m_out_x,
    input logic signed [VEC_W-1:0] m_out_y,
    input logic signed [VEC_W-1:0] m_out_z,
    input logic                    m_saturated,
    input logic                    m_bad_axis
);

    logic [3*VEC_W+1:0] m_word;

    // Pack the result word for the stability check
    assign m_word = {m_out_x, m_out_y, m_out_z, m_saturated, m_bad_axis};

    // Hold a stalled result word
    `AVR_ASSERT_NEXT(a_hold_valid, m_valid && !m_ready, m_valid)
    `AVR_ASSERT_NEXT(a_hold_word, m_valid && !m_ready, $stable(m_word))

    // Pass-through words never report clipping
    `AVR_ASSERT_NOW(a_flags_excl, m_valid, !(m_saturated && m_bad_axis))

    // Backpressure only when results wait at the output
    `AVR_ASSERT_NOW(a_ready_room, !s_ready, m_valid)

    // Come out of reset empty and ready
    `AVR_ASSERT_RESET(a_reset_empty, !aresetn, !m_valid && s_ready)

endmodule

bind axis_vector_rotator avr_checker u_avr_checker (.*);
